>>> sv/lffd_pkg.sv
// ----------------------------------------------------------------------------
// lffd_pkg
// Shared types and constants for the length field frame decoder.
// ----------------------------------------------------------------------------
package lffd_pkg;

  localparam int LFFD_MAX_HEADER = 64;
  localparam int CntW            = 7;
  localparam int TotW            = 34;
  localparam int RemW            = 33;
  localparam int CfgDataW        = 32;
  localparam int CfgIdxW         = 2;

  localparam logic [31:0] RST_MAX_FRAME_LENGTH  = 32'd65535;
  localparam logic [5:0]  RST_LENGTH_OFFSET     = 6'd0;
  localparam logic [1:0]  RST_LENGTH_SIZE_CODE  = 2'd1;
  localparam logic [15:0] RST_LENGTH_ADJUSTMENT = 16'd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_FRAME_LENGTH  = 2'd0,
    REG_LENGTH_OFFSET     = 2'd1,
    REG_LENGTH_SIZE_CODE  = 2'd2,
    REG_LENGTH_ADJUSTMENT = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ST_DATA  = 1'b0,
    ST_ERROR = 1'b1
  } status_e;

  typedef struct packed {
    logic [31:0] max_frame_length;
    logic [5:0]  length_offset;
    logic [1:0]  length_size_code;
    logic [15:0] length_adjustment;
  } cfg_t;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_last;
    logic       status;
  } out_item_t;

endpackage

>>> sv/lffd_stream_if.sv
// ----------------------------------------------------------------------------
// lffd_stream_if
// Valid/ready stream channel carrying one request payload.
// ----------------------------------------------------------------------------
interface lffd_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/lffd_ram.sv
// ----------------------------------------------------------------------------
// lffd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module lffd_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/lffd_cfg.sv
// ----------------------------------------------------------------------------
// lffd_cfg
// Configuration register bank written through a plain write port.
// ----------------------------------------------------------------------------
module lffd_cfg
  import lffd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_MAX_FRAME_LENGTH:  cfg_d.max_frame_length  = cfg_data_i;
        REG_LENGTH_OFFSET:     cfg_d.length_offset     = cfg_data_i[5:0];
        REG_LENGTH_SIZE_CODE:  cfg_d.length_size_code  = cfg_data_i[1:0];
        REG_LENGTH_ADJUSTMENT: cfg_d.length_adjustment = cfg_data_i[15:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_frame_length  <= RST_MAX_FRAME_LENGTH;
      cfg_q.length_offset     <= RST_LENGTH_OFFSET;
      cfg_q.length_size_code  <= RST_LENGTH_SIZE_CODE;
      cfg_q.length_adjustment <= RST_LENGTH_ADJUSTMENT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/lffd_ctrl.sv
// ----------------------------------------------------------------------------
// lffd_ctrl
// Frame sequencer: fills the header store, reads the length field back,
// checks the frame length, replays the header and passes the payload.
// ----------------------------------------------------------------------------
module lffd_ctrl
  import lffd_pkg::*;
#(
  parameter int MaxHeader = LFFD_MAX_HEADER,
  localparam int AddrW = (MaxHeader > 1) ? $clog2(MaxHeader) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  lffd_stream_if.sink      in_i,
  lffd_stream_if.source    out_o,
  output logic             ram_we_o,
  output logic [AddrW-1:0] ram_waddr_o,
  output logic [7:0]       ram_wdata_o,
  output logic             ram_re_o,
  output logic [AddrW-1:0] ram_raddr_o,
  input  logic [7:0]       ram_rdata_i
);

  typedef enum logic [6:0] {
    S_HDR  = 7'b0000001,
    S_LEN  = 7'b0000010,
    S_SUM  = 7'b0000100,
    S_CMP  = 7'b0001000,
    S_EMIT = 7'b0010000,
    S_PAY  = 7'b0100000,
    S_ERR  = 7'b1000000
  } state_e;

  localparam logic [CntW-1:0] MaxHdrC = CntW'(MaxHeader);

  state_e          state_q, state_d;
  logic [CntW-1:0] hc_q, hc_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            dv_q, dv_d;
  logic [2:0]      bi_q, bi_d;
  logic [31:0]     acc_q, acc_d;
  logic            ovf_q, ovf_d;
  logic [TotW-1:0] total_q, total_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic            pend_q, pend_d;
  logic            pend_last_q, pend_last_d;
  logic            ov_q, ov_d;
  out_item_t       out_q, out_d;

  logic [CntW-1:0] need;
  logic [3:0]      fsize;
  logic [CntW-1:0] hc_inc;
  logic [CntW-1:0] rd_addr;
  logic            out_free;
  logic            in_acc;
  logic            move;
  logic            issue;

  assign fsize    = 4'd1 << cfg_i.length_size_code;
  assign need     = CntW'(cfg_i.length_offset) + CntW'(fsize);
  assign hc_inc   = hc_q + 7'd1;
  assign out_free = !ov_q || out_o.ready;
  assign in_acc   = in_i.valid && in_i.ready;
  assign move     = (state_q == S_EMIT) && pend_q && out_free;
  assign issue    = (state_q == S_EMIT) && (idx_q < hc_q) && (!pend_q || move);

  always_comb begin
    case (state_q)
      S_HDR:   in_i.ready = out_free;
      S_PAY:   in_i.ready = out_free;
      S_ERR:   in_i.ready = 1'b1;
      default: in_i.ready = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    hc_d        = hc_q;
    idx_d       = idx_q;
    dv_d        = 1'b0;
    bi_d        = bi_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    total_d     = total_q;
    rem_d       = rem_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    ov_d        = ov_q && !out_o.ready;
    out_d       = out_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = hc_q[AddrW-1:0];
    ram_wdata_o = in_i.payload.in_byte;
    ram_re_o    = 1'b0;
    rd_addr     = CntW'(cfg_i.length_offset) + idx_q;
    ram_raddr_o = rd_addr[AddrW-1:0];

    case (state_q)
      S_HDR: begin
        if (in_acc) begin
          if (need > MaxHdrC) begin
            ov_d    = 1'b1;
            out_d   = '{out_byte: 8'd0, is_last: 1'b0, status: ST_ERROR};
            state_d = S_ERR;
          end else begin
            ram_we_o = 1'b1;
            hc_d     = hc_inc;
            if (hc_inc >= need) begin
              idx_d   = '0;
              acc_d   = '0;
              ovf_d   = 1'b0;
              state_d = S_LEN;
            end
          end
        end
      end
      S_LEN: begin
        if (idx_q < CntW'(fsize)) begin
          ram_re_o = 1'b1;
          idx_d    = idx_q + 7'd1;
          dv_d     = 1'b1;
          bi_d     = idx_q[2:0];
        end
        if (dv_q) begin
          if (!bi_q[2]) begin
            acc_d = acc_q | ({24'd0, ram_rdata_i} << {bi_q[1:0], 3'b000});
          end else if (ram_rdata_i != 8'd0) begin
            ovf_d = 1'b1;
          end
          if ({1'b0, bi_q} == fsize - 4'd1) begin
            state_d = S_SUM;
          end
        end
      end
      S_SUM: begin
        total_d = TotW'(need) + TotW'(acc_q) + TotW'(cfg_i.length_adjustment);
        state_d = S_CMP;
      end
      S_CMP: begin
        if (out_free) begin
          if (ovf_q || (total_q > TotW'(cfg_i.max_frame_length))) begin
            ov_d    = 1'b1;
            out_d   = '{out_byte: 8'd0, is_last: 1'b0, status: ST_ERROR};
            state_d = S_ERR;
          end else begin
            rem_d   = total_q[RemW-1:0] - RemW'(hc_q);
            idx_d   = '0;
            pend_d  = 1'b0;
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        ram_raddr_o = idx_q[AddrW-1:0];
        if (move) begin
          ov_d   = 1'b1;
          out_d  = '{out_byte: ram_rdata_i, is_last: pend_last_q, status: ST_DATA};
          pend_d = 1'b0;
        end
        if (issue) begin
          ram_re_o    = 1'b1;
          idx_d       = idx_q + 7'd1;
          pend_d      = 1'b1;
          pend_last_d = (rem_q == '0) && (idx_q + 7'd1 == hc_q);
        end else if (idx_q == hc_q && !pend_q) begin
          hc_d    = '0;
          state_d = (rem_q == '0) ? S_HDR : S_PAY;
        end
      end
      S_PAY: begin
        if (in_acc) begin
          rem_d = rem_q - 33'd1;
          ov_d  = 1'b1;
          out_d = '{out_byte: in_i.payload.in_byte, is_last: (rem_q == 33'd1),
                    status: ST_DATA};
          if (rem_q == 33'd1) begin
            state_d = S_HDR;
          end
        end
      end
      S_ERR: begin
        state_d = S_ERR;
      end
      default: begin
        state_d = S_HDR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_HDR;
      hc_q        <= '0;
      idx_q       <= '0;
      dv_q        <= 1'b0;
      bi_q        <= '0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      total_q     <= '0;
      rem_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      hc_q        <= hc_d;
      idx_q       <= idx_d;
      dv_q        <= dv_d;
      bi_q        <= bi_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      total_q     <= total_d;
      rem_q       <= rem_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid   = ov_q;
  assign out_o.payload = out_q;

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ERR |=> state_q == S_ERR)
    else $error("error phase left without reset");

  a_ram_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("header store written and read in one cycle");

  a_hc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q <= MaxHdrC)
    else $error("header count beyond store depth");

  a_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (state_q == S_HDR || state_q == S_PAY || state_q == S_ERR))
    else $error("request accepted while busy");

  a_emit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && state_d == S_HDR) |-> (ov_q && out_q.is_last))
    else $error("header burst ended without last marker on zero payload");

endmodule

>>> sv/length_field_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// length_field_frame_decoder_top
// Splits a byte stream into frames using a little-endian length field.
//
//   channel  dir  payload                       handshake
//   in_i     in   in_byte[7:0]                  valid/ready
//   out_o    out  out_byte[7:0] is_last status  valid/ready
//   cfg      in   cfg_idx_i[1:0] cfg_data_i[31:0]  cfg_we_i, no stall
//
// Header bytes: taken while the output is free, no result until the length field is complete.
// Completion: field read back from the header store byte by byte, then a sum
// state and a check state, then the header burst at one byte per cycle while
// the output takes it, through the single read port of the store.
// Payload: one byte per cycle while the output is free. After an error every byte is taken and dropped
// until reset. Output stalls hold the result register and stop intake.
// ----------------------------------------------------------------------------
module length_field_frame_decoder_top
  import lffd_pkg::*;
#(
  parameter int MaxHeader = LFFD_MAX_HEADER
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lffd_stream_if.sink         in_i,
  lffd_stream_if.source       out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int AddrW = (MaxHeader > 1) ? $clog2(MaxHeader) : 1;

  cfg_t             cfg;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  lffd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lffd_ram #(
    .Width (8),
    .Depth (MaxHeader)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lffd_ctrl #(
    .MaxHeader (MaxHeader)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the length field frame decoder. Random frames are
// built for a series of register settings and fed one byte per request. A
// byte-level shadow of the decoder predicts each output request, and every
// output is compared in order. The run ends on one error frame and a tail of
// bytes that must be dropped.
// ----------------------------------------------------------------------------
module tb;
  import lffd_pkg::*;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned SettleCycles = 100;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SegBytes     = 16;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_ERROR
  } dec_phase_e;

  typedef enum int {
    ERR_OVER_MAX,
    ERR_WIDE_FIELD,
    ERR_LONG_HEADER,
    ERR_SUM_WRAP
  } err_kind_e;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                cfg_we   = 1'b0;
  cfg_idx_e            cfg_idx  = REG_MAX_FRAME_LENGTH;
  logic [CfgDataW-1:0] cfg_data = '0;

  lffd_stream_if #(.payload_t(in_item_t))  in_if ();
  lffd_stream_if #(.payload_t(out_item_t)) out_if ();

  length_field_frame_decoder_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #4 clk = ~clk;

  // decoder shadow state
  cfg_t        cur_cfg;
  dec_phase_e  dec_phase;
  logic [6:0]  hdr_cnt;
  logic [7:0]  hdr_mem [LFFD_MAX_HEADER];
  logic [32:0] pay_left;

  logic [7:0]  byte_q[$];
  out_item_t   frame_q[$];
  int unsigned queued = 0;

  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  bit          hold_req     = 1'b0;
  bit          hold_done    = 1'b0;
  int unsigned hold_left    = 0;
  logic        in_fire      = 1'b0;
  int unsigned cycles       = 0;
  int unsigned fails        = 0;

  function automatic void enter_error();
    dec_phase = PH_ERROR;
    frame_q.push_back('{8'h00, 1'b0, ST_ERROR});
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int unsigned fsize;
    int unsigned need;
    logic [32:0] field;
    logic [33:0] total;
    logic [7:0]  v;
    fsize = 1 << cur_cfg.length_size_code;
    need  = cur_cfg.length_offset + fsize;
    if (dec_phase == PH_ERROR) return;
    if (dec_phase == PH_PAYLOAD) begin
      pay_left = pay_left - 33'd1;
      if (pay_left == 0) begin
        dec_phase = PH_HEADER;
        hdr_cnt   = '0;
        frame_q.push_back('{b, 1'b1, ST_DATA});
      end else begin
        frame_q.push_back('{b, 1'b0, ST_DATA});
      end
      return;
    end
    if (need > LFFD_MAX_HEADER) begin
      enter_error();
      return;
    end
    hdr_mem[hdr_cnt % LFFD_MAX_HEADER] = b;
    hdr_cnt = hdr_cnt + 7'd1;
    if (hdr_cnt < need) return;
    field = '0;
    for (int i = 0; i < fsize; i++) begin
      v = hdr_mem[(cur_cfg.length_offset + i) % LFFD_MAX_HEADER];
      if (i < 4) field[8*i +: 8] = v;
      else if (v != 0) field[32] = 1'b1;
    end
    total = need + field + cur_cfg.length_adjustment;
    if (field[32] || total > cur_cfg.max_frame_length) begin
      enter_error();
      return;
    end
    pay_left = 33'(total - hdr_cnt);
    for (int i = 0; i < hdr_cnt && i < LFFD_MAX_HEADER; i++) begin
      frame_q.push_back('{hdr_mem[i], (pay_left == 0 && i + 1 == hdr_cnt), ST_DATA});
    end
    dec_phase = (pay_left == 0) ? PH_HEADER : PH_PAYLOAD;
    hdr_cnt   = '0;
  endfunction

  // byte request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_if.payload.in_byte <= byte_q.pop_front();
        in_if.valid           <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // output receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left    <= HoldCycles;
      hold_done    <= 1'b1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    in_fire <= in_if.valid && in_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (frame_q.size() == 0) begin
        $display("%0t: unexpected output byte=%h last=%b status=%b", $time,
                 out_if.payload.out_byte, out_if.payload.is_last, out_if.payload.status);
        fails++;
      end else begin
        want = frame_q.pop_front();
        if (out_if.payload.out_byte !== want.out_byte ||
            out_if.payload.is_last !== want.is_last ||
            out_if.payload.status !== want.status) begin
          $display("%0t: mismatch exp byte=%h last=%b status=%b got byte=%h last=%b status=%b",
                   $time, want.out_byte, want.is_last, want.status,
                   out_if.payload.out_byte, out_if.payload.is_last, out_if.payload.status);
          fails++;
        end
      end
    end
    if (rst_n && in_if.valid && in_if.ready) decode_byte(in_if.payload.in_byte);
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic wait_idle();
    while (byte_q.size() != 0 || in_if.valid || frame_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
  endtask

  task automatic set_cfg(cfg_t c);
    wait_idle();
    write_reg(REG_MAX_FRAME_LENGTH, c.max_frame_length);
    write_reg(REG_LENGTH_OFFSET, CfgDataW'(c.length_offset));
    write_reg(REG_LENGTH_SIZE_CODE, CfgDataW'(c.length_size_code));
    write_reg(REG_LENGTH_ADJUSTMENT, CfgDataW'(c.length_adjustment));
    @(negedge clk);
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic put_byte(logic [7:0] b);
    byte_q.push_back(b);
    queued++;
  endtask

  task automatic push_bytes(int unsigned n);
    repeat (n) put_byte(8'($urandom));
  endtask

  // header with the length field placed at the configured offset
  task automatic push_header(logic [63:0] fval);
    int unsigned off;
    int unsigned fsize;
    off   = cur_cfg.length_offset;
    fsize = 1 << cur_cfg.length_size_code;
    for (int unsigned i = 0; i < off + fsize; i++) begin
      if (i >= off) put_byte(fval[8*(i-off) +: 8]);
      else put_byte(8'($urandom));
    end
  endtask

  task automatic send_frame(logic [63:0] fval);
    push_header(fval);
    push_bytes(fval[31:0] + cur_cfg.length_adjustment);
  endtask

  task automatic rand_cfg(output cfg_t c);
    int unsigned need;
    case ($urandom_range(0, 3))
      0:       c.length_offset = 6'd0;
      1:       c.length_offset = 6'd56;
      default: c.length_offset = 6'($urandom_range(0, 24));
    endcase
    c.length_size_code  = 2'($urandom_range(0, 3));
    c.length_adjustment = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
    need = c.length_offset + (1 << c.length_size_code);
    if ($urandom_range(0, 2) == 0) c.max_frame_length = 32'hFFFF_FFFF;
    else c.max_frame_length = need + c.length_adjustment + $urandom_range(0, 10);
  endtask

  task automatic rand_frame();
    longint unsigned room;
    longint unsigned lim;
    room = longint'(cur_cfg.max_frame_length) - cur_cfg.length_offset -
           (1 << cur_cfg.length_size_code) - cur_cfg.length_adjustment;
    lim  = (room < 12) ? room : 12;
    if ($urandom_range(0, 3) == 0) send_frame(lim);
    else send_frame($urandom_range(0, lim));
  endtask

  initial begin : stimulus
    cfg_t        c;
    err_kind_e   kind;
    logic [63:0] fval;
    int unsigned need;
    int unsigned seg_start;
    int unsigned nframes;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    out_if.ready  = 1'b0;
    cur_cfg   = '{RST_MAX_FRAME_LENGTH, RST_LENGTH_OFFSET, RST_LENGTH_SIZE_CODE,
                  RST_LENGTH_ADJUSTMENT};
    dec_phase = PH_HEADER;
    hdr_cnt   = '0;
    pay_left  = '0;
    send_gap_pct = 33;
    recv_gap_pct = 57;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: empty payload, then a payload of 0xff and 0x00
    send_frame(64'd0);
    push_header(64'd2);
    put_byte(8'hFF);
    put_byte(8'h00);
    // one-byte field after a short header, total equal to the maximum
    set_cfg('{32'd7, 6'd3, 2'd0, 16'd2});
    send_frame(64'd1);
    // eight-byte field, upper half zero
    set_cfg('{32'hFFFF_FFFF, 6'd1, 2'd3, 16'd0});
    send_frame(64'd1);
    set_cfg('{32'd5, 6'd0, 2'd2, 16'd1});
    send_frame(64'd0);

    for (int m = 0; m < 3; m++) begin
      wait_idle();
      case (m)
        0: begin
          send_gap_pct = 33;
          recv_gap_pct = 57;
        end
        1: begin
          send_gap_pct = 57;
          recv_gap_pct = 33;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      for (int s = 0; s < 4; s++) begin
        rand_cfg(c);
        if (m == 0 && s == 0) c = '{32'hFFFF_FFFF, 6'd56, 2'd3, 16'd0};
        if (m == 2 && s == 3) c = '{32'hFFFF_FFFF, 6'd0, 2'd0, 16'd40};
        set_cfg(c);
        if (m == 2 && s == 3) begin
          send_frame(64'd0);
        end else begin
          seg_start = queued;
          nframes   = 0;
          while (queued - seg_start < SegBytes) begin
            rand_frame();
            nframes++;
            if (m == 0 && s == 1 && nframes == 2) wait_idle();
          end
          if (m == 2 && s == 0) hold_req = 1'b1;
        end
      end
    end

    // terminal error, then bytes that must be dropped
    kind = err_kind_e'($urandom_range(0, 3));
    c.length_offset     = 6'($urandom_range(0, 8));
    c.length_adjustment = 16'($urandom_range(0, 6));
    c.max_frame_length  = 32'hFFFF_FFFF;
    fval = {$urandom, $urandom};
    case (kind)
      ERR_OVER_MAX: begin
        c.length_size_code = 2'($urandom_range(0, 2));
        fval = 64'($urandom_range(1, 10));
        need = c.length_offset + (1 << c.length_size_code);
        c.max_frame_length = ($urandom_range(0, 1) == 0) ? 32'd0 :
                             need + c.length_adjustment + fval[31:0] - 1;
      end
      ERR_WIDE_FIELD: begin
        c.length_size_code = 2'd3;
        fval[63:32] = $urandom_range(1, 32'hFFFF_FFFF);
      end
      ERR_LONG_HEADER: begin
        c.length_offset    = 6'($urandom_range(57, 63));
        c.length_size_code = 2'd3;
      end
      default: begin
        c.length_size_code = 2'd2;
        fval = 64'h0000_0000_FFFF_FFFF;
      end
    endcase
    set_cfg(c);
    push_header(fval);
    push_bytes(12);

    wait_idle();
    repeat (SettleCycles) @(posedge clk);
    if (frame_q.size() != 0) begin
      $display("%0t: %0d expected outputs never arrived", $time, frame_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
